/* rtl/slew_limiter_reversal_dwell_unit_macros.svh */
// Assertion macros for the slew limiter with reversal dwell.
// Included by files that check their own logic; empty when SYNTHESIS is set.
`ifndef SLEW_LIMITER_REVERSAL_DWELL_UNIT_MACROS_SVH
`define SLEW_LIMITER_REVERSAL_DWELL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SLRD_ASSERT_IMPL(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("slrd assertion failed");
// next-cycle implication
`define SLRD_ASSERT_NEXT(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error("slrd assertion failed");
`else
`define SLRD_ASSERT_IMPL(label, clk, rst, ant, cons)
`define SLRD_ASSERT_NEXT(label, clk, rst, ant, cons)
`endif
`endif

/* rtl/slrd_pkg.sv */
// Shared types and constants for the slew limiter with reversal dwell.
// No dependencies; used by slrd_csr, the top level and the testbench.
package slrd_pkg;

   localparam int RATE_W     = 31;
   localparam int DWELL_W    = 16;
   localparam int COUNT_W    = 17;
   localparam int STEP_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int DWELL_BIAS = 2;

   localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(1);
   localparam logic [DWELL_W-1:0] DWELL_RESET = '0;

   typedef enum logic {
      CSR_RATE_LIMIT     = 1'b0,
      CSR_REVERSAL_DWELL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [RATE_W-1:0]  rate_limit;
      logic [DWELL_W-1:0] reversal_dwell;
   } cfg_type;

endpackage

/* rtl/slew_limiter_reversal_dwell_unit.sv */
// Slew limiter with reversal dwell: top level, request/result pipeline and state.
// Depends on slrd_pkg, slrd_csr and slew_limiter_reversal_dwell_unit_macros.svh.
//
//   channel  | direction | handshake         | payload
//   req      | in        | valid/ready       | request
//   rsp      | out       | valid/ready       | output_value, step, holding
//   csr      | in        | APB psel/penable  | rate_limit, reversal_dwell
//
// One request per cycle sustained while results are taken; a request passes the input
// register, then limiter logic into the result register, which also updates the held state.
// Synchronous active-high reset clears held output, step sign, counter and
// registers rate_limit to 1, reversal_dwell to 0.
// A stalled result holds the result register; the input register still takes
// one more request, then req_ready drops until the result is taken.
`include "slew_limiter_reversal_dwell_unit_macros.svh"
module slew_limiter_reversal_dwell_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [DATA_WIDTH-1:0]          req_request,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [DATA_WIDTH-1:0]          rsp_output_value,
   output logic signed [slrd_pkg::STEP_W-1:0]    rsp_step,
   output logic                                  rsp_holding,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [slrd_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [slrd_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [slrd_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import slrd_pkg::*;

   localparam int CalcW = (DATA_WIDTH + 1 > STEP_W) ? DATA_WIDTH + 1 : STEP_W;

   cfg_type cfg;

   logic                         in_valid_ff;
   logic signed [DATA_WIDTH-1:0] req_ff;
   logic                         out_valid_ff;
   logic signed [DATA_WIDTH-1:0] out_value_ff;
   logic signed [STEP_W-1:0]     out_step_ff;
   logic                         out_holding_ff;

   logic signed [DATA_WIDTH-1:0] held_ff;
   logic                         applied_pos_ff;
   logic                         applied_neg_ff;
   logic [COUNT_W-1:0]           count_ff;

   logic                         fire;
   logic signed [CalcW-1:0]      diff;
   logic signed [CalcW-1:0]      lim_wide;
   logic signed [STEP_W-1:0]     lim_step;
   logic                         lim_nz;
   logic                         step_pos;
   logic                         step_neg;
   logic signed [DATA_WIDTH-1:0] pending;
   logic signed [STEP_W-1:0]     step_in;
   logic                         opposite;
   logic [COUNT_W-1:0]           count_inc;
   logic [COUNT_W-1:0]           dwell_end;
   logic [COUNT_W-1:0]           count_in;
   logic                         apply;

   slrd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign fire      = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | fire;

   assign rsp_valid        = out_valid_ff;
   assign rsp_output_value = out_value_ff;
   assign rsp_step         = out_step_ff;
   assign rsp_holding      = out_holding_ff;

   assign diff     = CalcW'(req_ff) - CalcW'(held_ff);
   assign lim_wide = CalcW'({1'b0, cfg.rate_limit});
   assign lim_step = {1'b0, cfg.rate_limit};
   assign lim_nz   = |cfg.rate_limit;
   assign step_pos = diff > lim_wide;
   assign step_neg = diff < -lim_wide;

   always_comb begin
      if (step_pos) begin
         pending = DATA_WIDTH'(CalcW'(held_ff) + lim_wide);
         step_in = lim_step;
      end else if (step_neg) begin
         pending = DATA_WIDTH'(CalcW'(held_ff) - lim_wide);
         step_in = -lim_step;
      end else begin
         pending = req_ff;
         step_in = '0;
      end
   end

   // a zero limit gives a zero step, which has no sign
   assign opposite  = lim_nz & ((step_pos & applied_neg_ff) | (step_neg & applied_pos_ff));
   assign count_inc = opposite ? count_ff + COUNT_W'(1) : count_ff;
   assign dwell_end = COUNT_W'(cfg.reversal_dwell) + COUNT_W'(DWELL_BIAS);
   assign count_in  = (count_inc == dwell_end) ? '0 : count_inc;
   assign apply     = (count_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         held_ff        <= '0;
         applied_pos_ff <= 1'b0;
         applied_neg_ff <= 1'b0;
         count_ff       <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (fire) begin
            count_ff <= count_in;
            if (apply) begin
               held_ff        <= pending;
               applied_pos_ff <= step_pos & lim_nz;
               applied_neg_ff <= step_neg & lim_nz;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready & req_valid) begin
         req_ff <= req_request;
      end
      if (fire) begin
         out_value_ff   <= apply ? pending : held_ff;
         out_step_ff    <= step_in;
         out_holding_ff <= ~apply;
      end
   end

   `SLRD_ASSERT_NEXT(a_frozen_holds, clock, reset, fire && !apply, held_ff == $past(held_ff))
   `SLRD_ASSERT_IMPL(a_step_mag, clock, reset, rsp_valid,
      rsp_step == '0 || rsp_step == lim_step || rsp_step == -lim_step)
   `SLRD_ASSERT_IMPL(a_holding_count, clock, reset, rsp_valid,
      rsp_holding == (count_ff != '0))
   `SLRD_ASSERT_IMPL(a_no_fire_no_room, clock, reset, in_valid_ff && !fire, !req_ready)

endmodule

/* rtl/slrd_csr.sv */
// APB-style register file: rate limit and reversal dwell.
// Depends on slrd_pkg.
module slrd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [slrd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [slrd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [slrd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output slrd_pkg::cfg_type                  cfg
);
   import slrd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      unique case (index)
         CSR_RATE_LIMIT: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.rate_limit);
            if (wr_en) cfg_in.rate_limit = csr_pwdata[RATE_W-1:0];
         end
         CSR_REVERSAL_DWELL: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.reversal_dwell);
            if (wr_en) cfg_in.reversal_dwell = csr_pwdata[DWELL_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_limit     <= RATE_RESET;
         cfg_ff.reversal_dwell <= DWELL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* test/slew_limiter_reversal_dwell_unit_test.sv */
// Self-checking testbench for slew_limiter_reversal_dwell_unit: a queue-fed request driver,
// APB register writes per phase, and an in-line slew/dwell predictor checked per result.
// Depends on slrd_pkg and the unit RTL only.
module slew_limiter_reversal_dwell_unit_test;
   import slrd_pkg::*;

   localparam int DATA_W      = 32;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int LONG_STALL  = 400;
   localparam int MAX_REPORTS = 10;
   localparam int RAND_PHASES = 12;

   typedef logic signed [DATA_W-1:0] sample_type;

   localparam sample_type REQ_MAX = sample_type'(32'h7FFF_FFFF);
   localparam sample_type REQ_MIN = sample_type'(32'h8000_0000);

   typedef struct {
      sample_type                output_value;
      logic signed [STEP_W-1:0]  step;
      logic                      holding;
   } slew_result_type;

   typedef enum int {RX_ALWAYS, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid;
   logic                     req_ready;
   sample_type               req_request;
   logic                     rsp_valid;
   logic                     rsp_ready;
   sample_type               rsp_output_value;
   logic signed [STEP_W-1:0] rsp_step;
   logic                     rsp_holding;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [CSR_DATA_W-1:0]    csr_pwdata;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   // predictor state and register shadow
   sample_type               held_value;
   longint                   last_applied_step;
   logic [COUNT_W-1:0]       reversal_count;
   logic [RATE_W-1:0]        limit_cfg;
   logic [DWELL_W-1:0]       dwell_cfg;

   sample_type               request_queue[$];
   slew_result_type          expected_results[$];

   int          requests_queued = 0;
   int          requests_taken  = 0;
   int          results_checked = 0;
   int          holding_seen    = 0;
   int          failures        = 0;
   int          settings_used   = 0;
   int          cycle_count     = 0;
   bit          req_taken       = 1'b0;
   bit          sender_bursty   = 1'b0;
   int          burst_left      = 0;
   int          gap_left        = 0;
   rx_mode_type receiver_mode   = RX_ALWAYS;
   int          stall_phase     = 0;
   bit          long_stall_armed = 1'b0;
   int          long_stall_left = 0;

   slew_limiter_reversal_dwell_unit #(.DATA_WIDTH(DATA_W)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_request      (req_request),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_output_value (rsp_output_value),
      .rsp_step         (rsp_step),
      .rsp_holding      (rsp_holding),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one tick of the limiter: step toward target, count reversals, freeze while counting
   function automatic slew_result_type predict_tick(input sample_type target);
      longint          t_val;
      longint          h_val;
      longint          lim;
      longint          next_val;
      longint          dir_step;
      logic            reversed;
      slew_result_type r;
      t_val = target;
      h_val = held_value;
      lim   = longint'(limit_cfg);
      if (t_val > h_val + lim) begin
         dir_step = lim;
         next_val = h_val + lim;
      end else if (t_val < h_val - lim) begin
         dir_step = -lim;
         next_val = h_val - lim;
      end else begin
         dir_step = 0;
         next_val = t_val;
      end
      reversed = (dir_step > 0 && last_applied_step < 0) ||
                 (dir_step < 0 && last_applied_step > 0);
      if (reversed)
         reversal_count = reversal_count + 1'b1;
      if (reversal_count == COUNT_W'(dwell_cfg) + COUNT_W'(DWELL_BIAS))
         reversal_count = '0;
      if (reversal_count == '0) begin
         held_value        = sample_type'(next_val);
         last_applied_step = dir_step;
      end
      r.output_value = held_value;
      r.step         = STEP_W'(dir_step);
      r.holding      = (reversal_count != '0);
      return r;
   endfunction

   function automatic void offer(input sample_type value);
      request_queue.push_back(value);
      requests_queued++;
   endfunction

   task automatic write_register(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == CSR_RATE_LIMIT)
         limit_cfg = value[RATE_W-1:0];
      else
         dwell_cfg = value[DWELL_W-1:0];
   endtask

   // upper bits beyond each register are random
   task automatic configure(input logic [RATE_W-1:0] rate, input logic [DWELL_W-1:0] dwell);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom();
      word[RATE_W-1:0] = rate;
      write_register(CSR_RATE_LIMIT, word);
      word = $urandom();
      word[DWELL_W-1:0] = dwell;
      write_register(CSR_REVERSAL_DWELL, word);
      settings_used++;
   endtask

   task automatic wait_idle();
      while (requests_taken != requests_queued || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_queue.size() > 0) begin
            req_valid   <= 1'b1;
            req_request <= request_queue.pop_front();
            if (sender_bursty) begin
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(24, 1);
                  gap_left   = $urandom_range(6, 1);
               end else begin
                  burst_left--;
               end
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      stall_phase++;
      if (long_stall_armed) begin
         long_stall_left  = LONG_STALL;
         long_stall_armed = 1'b0;
      end
      if (long_stall_left > 0) begin
         long_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (receiver_mode)
            RX_ALWAYS:  rsp_ready <= 1'b1;
            RX_LIGHT:   rsp_ready <= ($urandom_range(9, 0) >= 3);
            RX_PATTERN: rsp_ready <= ((stall_phase % 5) < 3);
            default:    rsp_ready <= ($urandom_range(9, 0) >= 7);
         endcase
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      slew_result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("unexpected result: value %0d step %0d holding %0b",
                           rsp_output_value, rsp_step, rsp_holding);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_holding === 1'b1)
                  holding_seen++;
               if (rsp_output_value !== want.output_value || rsp_step !== want.step ||
                   rsp_holding !== want.holding) begin
                  failures++;
                  if (failures <= MAX_REPORTS)
                     $display({"result %0d: expected value %0d step %0d holding %0b, ",
                               "got value %0d step %0d holding %0b"},
                              results_checked, want.output_value, want.step, want.holding,
                              rsp_output_value, rsp_step, rsp_holding);
               end
            end
         end
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            requests_taken++;
            expected_results.push_back(predict_tick(req_request));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, expected_results.size());
         $display("slew_limiter_reversal_dwell_unit test failed");
         $finish;
      end
   end

   initial begin
      int                 p;
      int                 n;
      int                 items;
      int unsigned        pick;
      longint             cursor;
      longint             dir;
      longint             span;
      sample_type         last_target;
      logic [RATE_W-1:0]  rate;
      logic [DWELL_W-1:0] dwell;

      req_valid   = 1'b0;
      req_request = '0;
      rsp_ready   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      held_value        = '0;
      last_applied_step = 0;
      reversal_count    = '0;
      limit_cfg         = RATE_RESET;
      dwell_cfg         = DWELL_RESET;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // freeze without reversal, then lower dwell under the count, count past it, release
      configure(RATE_W'(1000), DWELL_W'(10));
      offer(REQ_MAX);
      offer(REQ_MIN);
      offer(REQ_MIN);
      offer(sample_type'(1000));
      offer(REQ_MAX);
      offer(REQ_MIN);
      offer(REQ_MIN);
      wait_idle();
      write_register(CSR_REVERSAL_DWELL, CSR_DATA_W'(0));
      for (n = 0; n < 8; n++)
         offer(REQ_MIN);
      wait_idle();
      write_register(CSR_REVERSAL_DWELL, CSR_DATA_W'(reversal_count - 1));
      offer(REQ_MIN);
      offer(REQ_MIN);
      wait_idle();

      // normal dwell sequence with landings on the request
      configure(RATE_W'(100), DWELL_W'(2));
      offer(REQ_MAX);
      for (n = 0; n < 4; n++)
         offer(REQ_MIN);
      offer(sample_type'(0));
      offer(sample_type'(150));
      offer(sample_type'(30));
      offer(sample_type'(-1));
      offer(REQ_MAX);
      wait_idle();

      // zero rate: step is zero and the output holds unless the request matches it
      configure('0, '0);
      offer(REQ_MAX);
      offer(REQ_MIN);
      offer(sample_type'(0));
      offer(sample_type'(-1));
      offer(sample_type'(1));
      offer(sample_type'(32'h5555_5555));
      offer(sample_type'(32'hAAAA_AAAA));
      wait_idle();

      // widest rate and longest dwell
      configure('1, '1);
      offer(REQ_MIN);
      offer(REQ_MAX);
      offer(REQ_MAX);
      offer(sample_type'(0));
      offer(REQ_MIN);
      offer(REQ_MAX);
      wait_idle();

      for (p = 0; p < RAND_PHASES; p++) begin
         items = 150;
         if (p == 0) begin
            rate  = RATE_W'(1 << 30);
            dwell = '0;
         end else if (p == 1) begin
            rate  = '1;
            dwell = '1;
            items = 80;
         end else if (p == 2) begin
            rate  = '0;
            dwell = DWELL_W'($urandom_range(8, 0));
         end else if (p == 3) begin
            rate  = RATE_W'(1);
            dwell = DWELL_W'(1);
         end else begin
            case ($urandom_range(5, 0))
               0:       rate = '0;
               1:       rate = RATE_W'(1);
               2:       rate = RATE_W'($urandom_range(64, 1));
               3:       rate = RATE_W'($urandom_range(1 << 20, 65));
               4:       rate = RATE_W'(1 << 30);
               default: rate = RATE_W'($urandom());
            endcase
            pick = $urandom_range(19, 0);
            if (pick < 4)
               dwell = '0;
            else if (pick < 7)
               dwell = DWELL_W'(1);
            else if (pick < 18)
               dwell = DWELL_W'($urandom_range(8, 2));
            else
               dwell = DWELL_W'($urandom());
         end
         // keep the count below the new release point
         if (reversal_count > COUNT_W'(dwell) + 1)
            dwell = DWELL_W'(reversal_count - 1);
         configure(rate, dwell);

         sender_bursty = (p % 3 != 0);
         receiver_mode = rx_mode_type'(p % 4);
         if (p == 3)
            long_stall_armed = 1'b1;

         cursor      = held_value;
         dir         = 1;
         span        = (rate == '0) ? 1000 : longint'(rate);
         last_target = held_value;
         for (n = 0; n < items; n++) begin
            pick = $urandom_range(99, 0);
            if (pick < 8) begin
               last_target = sample_type'($urandom());
            end else if (pick < 12) begin
               last_target = ($urandom_range(1, 0) == 1) ? REQ_MAX : REQ_MIN;
            end else if (pick >= 20) begin
               if ($urandom_range(2, 0) == 0)
                  dir = -dir;
               cursor = cursor + dir * (span * longint'($urandom_range(3, 0)) +
                                        longint'($urandom_range(255, 0)));
               if (cursor > longint'(REQ_MAX))
                  cursor = longint'(REQ_MAX);
               if (cursor < longint'(REQ_MIN))
                  cursor = longint'(REQ_MIN);
               last_target = sample_type'(cursor);
            end
            offer(last_target);
         end
         wait_idle();
      end

      $display("ran %0d requests through %0d register settings, %0d results checked",
               requests_taken, settings_used, results_checked);
      $display("%0d results held by reversal dwell, %0d failures", holding_seen, failures);
      if (failures == 0 && expected_results.size() == 0)
         $display("slew_limiter_reversal_dwell_unit test passed");
      else
         $display("slew_limiter_reversal_dwell_unit test failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/slrd_pkg.sv
rtl/slrd_csr.sv
rtl/slew_limiter_reversal_dwell_unit.sv
test/slew_limiter_reversal_dwell_unit_test.sv
